// ===== sv/shc_pkg.sv =====
// shared types and constants of the substring hash compare core
`default_nettype none

package shc_pkg;

	// string storage
	localparam int MAX_LEN = 4096;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int LEN_W   = 13;

	// word fields
	localparam int CMD_W  = 2;
	localparam int CHAR_W = 8;
	localparam int HASH_W = 32;

	localparam logic [HASH_W-1:0] HASH_BASE = 32'd997;
	localparam logic [HASH_W-1:0] HASH_ONE  = 32'd1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COMPARE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic {
		OP_APPEND,
		OP_QUERY
	} op_t;

	// one classified word handed to the back end
	typedef struct packed {
		op_t                     op;
		logic [CHAR_W-1:0]       char_byte;
		logic                    first;    // append into an empty string
		logic [ADDR_W-1:0]       wr_addr;
		logic                    bad;
		logic                    go;       // well formed and lengths match
		logic [ADDR_W-1:0]       addr_b;   // end of first range, 0-based
		logic [ADDR_W-1:0]       addr_a2;  // entry just below first range
		logic                    a_is1;
		logic [ADDR_W-1:0]       addr_d;
		logic [ADDR_W-1:0]       addr_c2;
		logic                    c_is1;
	} work_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APP,
		ST_RD,
		ST_MUL,
		ST_RES
	} back_state_t;

endpackage

`default_nettype wire

// ===== sv/shc_front.sv =====
// front end: accepts words, tracks string length, classifies queries
`default_nettype none

module shc_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_valid,
	output logic                             cmd_stall,
	input  wire logic [shc_pkg::CMD_W-1:0]   cmd,
	input  wire logic [shc_pkg::CHAR_W-1:0]  char_byte,
	input  wire logic [shc_pkg::LEN_W-1:0]   first_start,
	input  wire logic [shc_pkg::LEN_W-1:0]   first_end,
	input  wire logic [shc_pkg::LEN_W-1:0]   second_start,
	input  wire logic [shc_pkg::LEN_W-1:0]   second_end,
	input  wire logic                        q_full,
	output logic                             q_push,
	output shc_pkg::work_t                   q_data
);
	import shc_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic             accept;
	logic             not_full_str;
	logic             bad;
	logic [LEN_W-1:0] span_first;
	logic [LEN_W-1:0] span_second;
	logic [LEN_W-1:0] b_m1;
	logic [LEN_W-1:0] a_m2;
	logic [LEN_W-1:0] d_m1;
	logic [LEN_W-1:0] c_m2;

	assign cmd_stall    = q_full;
	assign accept       = cmd_valid && !cmd_stall;
	assign not_full_str = (len_q < LEN_W'(MAX_LEN));

	// range checks against the current length
	assign bad = (first_start == '0) || (second_start == '0) ||
		(first_end < first_start) || (second_end < second_start) ||
		(first_end > len_q) || (second_end > len_q);

	assign span_first  = first_end - first_start;
	assign span_second = second_end - second_start;
	assign b_m1        = first_end - LEN_W'(1);
	assign a_m2        = first_start - LEN_W'(2);
	assign d_m1        = second_end - LEN_W'(1);
	assign c_m2        = second_start - LEN_W'(2);

	// build the word for the back end
	always_comb begin
		q_data.op        = (cmd == CMD_APPEND) ? OP_APPEND : OP_QUERY;
		q_data.char_byte = char_byte;
		q_data.first     = (len_q == '0);
		q_data.wr_addr   = len_q[ADDR_W-1:0];
		q_data.bad       = bad;
		q_data.go        = !bad && (span_first == span_second);
		q_data.addr_b    = b_m1[ADDR_W-1:0];
		q_data.addr_a2   = a_m2[ADDR_W-1:0];
		q_data.a_is1     = (first_start == LEN_W'(1));
		q_data.addr_d    = d_m1[ADDR_W-1:0];
		q_data.addr_c2   = c_m2[ADDR_W-1:0];
		q_data.c_is1     = (second_start == LEN_W'(1));
	end

	// appends past the end and unused codes are dropped here
	assign q_push = accept &&
		(((cmd == CMD_APPEND) && not_full_str) || (cmd == CMD_COMPARE));

	// stored length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (accept) begin
			if ((cmd == CMD_APPEND) && not_full_str) begin
				len_q <= len_q + LEN_W'(1);
			end else if (cmd == CMD_CLEAR) begin
				len_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/shc_queue.sv =====
// short queue of classified words between front and back
`default_nettype none

module shc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire shc_pkg::work_t  push_data,
	output logic                 full,
	input  wire logic            pop,
	output shc_pkg::work_t       head,
	output logic                 empty
);
	import shc_pkg::*;

	work_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== sv/shc_back.sv =====
// back end: hash tables, append arithmetic, query compare, result register
`default_nettype none

module shc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire shc_pkg::work_t  head,
	input  wire logic            q_empty,
	output logic                 q_pop,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output logic                 equal,
	output logic                 bad_query
);
	import shc_pkg::*;

	// tables
	logic [HASH_W-1:0] prefix_mem [MAX_LEN];
	logic [HASH_W-1:0] power_mem  [MAX_LEN];

	back_state_t       state_q;
	back_state_t       state_next;
	work_t             cur_q;
	logic              res_load;
	logic              res_valid_q;
	logic              equal_q;
	logic              bad_q;

	logic [ADDR_W-1:0] ph_addr0;
	logic [ADDR_W-1:0] ph_addr1;
	logic [HASH_W-1:0] ph_rd0_q;
	logic [HASH_W-1:0] ph_rd1_q;
	logic [HASH_W-1:0] pw_rd0_q;
	logic [HASH_W-1:0] pw_rd1_q;

	logic [HASH_W-1:0] last_pw_q;
	logic [HASH_W-1:0] last_ph_q;
	logic [HASH_W-1:0] pw_q;
	logic [HASH_W-1:0] pw_base;
	logic [2*HASH_W-1:0] pw_prod;
	logic [CHAR_W:0]   char_inc;
	logic [HASH_W+CHAR_W:0] app_prod;
	logic [HASH_W-1:0] ph_new;
	logic              app_wr;

	logic [HASH_W-1:0] x_q;
	logic [HASH_W-1:0] powc_q;
	logic [HASH_W-1:0] powa_q;
	logic [HASH_W-1:0] y_val;
	logic [2*HASH_W-1:0] prod_x;
	logic [2*HASH_W-1:0] prod_y;
	logic [HASH_W-1:0] prod_x_q;
	logic [HASH_W-1:0] prod_y_q;

	// next state and handshakes
	always_comb begin
		state_next = state_q;
		q_pop      = 1'b0;
		res_load   = 1'b0;
		app_wr     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (head.op == OP_APPEND) begin
						state_next = ST_APP;
					end else if (head.go) begin
						state_next = ST_RD;
					end else begin
						state_next = ST_RES;
					end
				end
			end
			ST_APP: begin
				app_wr     = 1'b1;
				state_next = ST_IDLE;
			end
			ST_RD: begin
				state_next = ST_MUL;
			end
			ST_MUL: begin
				state_next = ST_RES;
			end
			ST_RES: begin
				if (!res_valid_q || !res_stall) begin
					res_load   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// prefix reads: first range at pop, second range in ST_RD
	assign ph_addr0 = (state_q == ST_IDLE) ? head.addr_b  : cur_q.addr_d;
	assign ph_addr1 = (state_q == ST_IDLE) ? head.addr_a2 : cur_q.addr_c2;

	// append arithmetic
	assign pw_base  = head.first ? HASH_ONE : last_pw_q;
	assign pw_prod  = pw_base * HASH_BASE;
	assign char_inc = {1'b0, cur_q.char_byte} + (CHAR_W + 1)'(1);
	assign app_prod = char_inc * pw_q;
	assign ph_new   = (cur_q.first ? '0 : last_ph_q) + app_prod[HASH_W-1:0];

	// query arithmetic
	assign y_val  = ph_rd0_q - (cur_q.c_is1 ? '0 : ph_rd1_q);
	assign prod_x = x_q * powc_q;
	assign prod_y = y_val * powa_q;

	// table write and registered reads
	always_ff @(posedge clk) begin
		if (app_wr) begin
			prefix_mem[cur_q.wr_addr] <= ph_new;
			power_mem[cur_q.wr_addr]  <= pw_q;
		end
		ph_rd0_q <= prefix_mem[ph_addr0];
		ph_rd1_q <= prefix_mem[ph_addr1];
		pw_rd0_q <= power_mem[head.addr_c2];
		pw_rd1_q <= power_mem[head.addr_a2];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= head;
			pw_q  <= pw_prod[HASH_W-1:0];
		end
		if (app_wr) begin
			last_pw_q <= pw_q;
			last_ph_q <= ph_new;
		end
		if (state_q == ST_RD) begin
			x_q    <= ph_rd0_q - (cur_q.a_is1 ? '0 : ph_rd1_q);
			powc_q <= cur_q.c_is1 ? HASH_ONE : pw_rd0_q;
			powa_q <= cur_q.a_is1 ? HASH_ONE : pw_rd1_q;
		end
		if (state_q == ST_MUL) begin
			prod_x_q <= prod_x[HASH_W-1:0];
			prod_y_q <= prod_y[HASH_W-1:0];
		end
		if (res_load) begin
			equal_q <= cur_q.go && (prod_x_q == prod_y_q);
			bad_q   <= cur_q.bad;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign equal     = equal_q;
	assign bad_query = bad_q;

endmodule

`default_nettype wire

// ===== sv/substring_hash_compare_core.sv =====
// Substring equality by polynomial prefix hashes (base 997, mod 2^32).
// A compare word goes through the queue, then the back end states ST_RD, ST_MUL
// and ST_RES, which registers the result when res_stall allows (straight to ST_RES
// when malformed or lengths differ). Clear stays in the front; appends take ST_APP.
// ST_RD is the second round on the two-port prefix table; pops only in ST_IDLE.
// Reset: stored length, queue and result valid flag clear at once; hash tables
// are not cleared, since only entries below the stored length are ever used.
`default_nettype none

module substring_hash_compare_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_valid,
	output logic                             cmd_stall,
	input  wire logic [shc_pkg::CMD_W-1:0]   cmd,
	input  wire logic [shc_pkg::CHAR_W-1:0]  char_byte,
	input  wire logic [shc_pkg::LEN_W-1:0]   first_start,
	input  wire logic [shc_pkg::LEN_W-1:0]   first_end,
	input  wire logic [shc_pkg::LEN_W-1:0]   second_start,
	input  wire logic [shc_pkg::LEN_W-1:0]   second_end,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output logic                             equal,
	output logic                             bad_query
);
	import shc_pkg::*;

	work_t push_data;
	work_t head;
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;

	// classify incoming words
	shc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd          (cmd),
		.char_byte    (char_byte),
		.first_start  (first_start),
		.first_end    (first_end),
		.second_start (second_start),
		.second_end   (second_end),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (push_data)
	);

	// decoupling queue
	shc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (head),
		.empty     (q_empty)
	);

	// tables and compare
	shc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.equal     (equal),
		.bad_query (bad_query)
	);

endmodule

`default_nettype wire
